/* src/gfbc_pkg.sv */
// Package for the gyro filter and bias calibration block.
// Holds the phase codes, register indexes, state machine type and widths.
package gfbc_pkg;
   localparam int RATE_W = 21;
   localparam int CSR_W = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [2:0] REG_RANGE = 3'd0;
   localparam logic [2:0] REG_ALPHA = 3'd1;
   localparam logic [2:0] REG_THRESH = 3'd2;
   localparam logic [2:0] REG_COUNT = 3'd3;
   localparam logic [2:0] REG_TIMEOUT = 3'd4;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_RUN = 2'd1;
   localparam logic [1:0] PHASE_OK = 2'd2;
   localparam logic [1:0] PHASE_TIMEOUT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT,
      ST_TEST,
      ST_DIV,
      ST_OUT
   } state_type;
endpackage

/* src/gfbc_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type is given by the user.
interface gfbc_if #(
   parameter int W = 1
) ();
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* src/gyro_filter_bias_calibration_top.sv */
// Gyro rate scaling, low-pass filter and static bias calibration.
// Depends on gfbc_pkg, gfbc_if, gfbc_sermul and gfbc_serdiv.
//
// One item is processed at a time: a new item is taken only when the block is
// idle and its last result beat has left with the receiver ready. Each axis
// needs a scaling pass and a filter blend pass on the shared shift-add
// multiplier. Each pass is a start, one step per multiplier bit and a collect.
// Around the passes come the accept, the stillness test, the building of the
// result beat and the hand-off. The first valid sample after reset loads the
// filter directly and skips the blend passes. An invalid sample goes straight
// to the stillness test, and a start command straight to the result beat. A
// sample that ends a calibration adds three divider passes. Receiver stalls
// hold the block until the result beat is taken. That beat sits in an output
// register, and the next item is taken in the cycle after that beat is gone.
module gyro_filter_bias_calibration_top
   import gfbc_pkg::*;
#(
   parameter int RAW_WIDTH = 16,
   parameter int RATE_FRAC_BITS = 8,
   parameter int SUM_WIDTH = 40
) (
   input  logic clock,
   input  logic reset,
   gfbc_if.sink req,
   gfbc_if.source rsp,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);
   // Product width: raw*125*2^F fits raw + 7 + F bits.
   localparam int MA_W = (RAW_WIDTH + 7 + RATE_FRAC_BITS > RATE_W + 1)
                         ? RAW_WIDTH + 7 + RATE_FRAC_BITS : RATE_W + 1;
   localparam int MB_W = 10;
   localparam int MP_W = MA_W + MB_W;
   localparam int RUN_W = 16;

   typedef struct packed {
      logic command;
      logic read_ok;
      logic signed [RAW_WIDTH-1:0] raw_x;
      logic signed [RAW_WIDTH-1:0] raw_y;
      logic signed [RAW_WIDTH-1:0] raw_z;
   } req_type;

   typedef struct packed {
      logic data_valid;
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
      logic bias_valid;
      logic [1:0] cal_status;
   } rsp_type;

   // Configuration registers.
   logic [2:0] range_ff;
   logic [8:0] alpha_ff;
   logic [19:0] thresh_ff;
   logic [15:0] count_ff;
   logic [23:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 3'd0;
         alpha_ff <= 9'd77;
         thresh_ff <= 20'd768;
         count_ff <= 16'd1500;
         timeout_ff <= 24'd100000;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RANGE: range_ff <= csr_wdata[2:0];
            REG_ALPHA: alpha_ff <= csr_wdata[8:0];
            REG_THRESH: thresh_ff <= csr_wdata[19:0];
            REG_COUNT: count_ff <= csr_wdata[15:0];
            REG_TIMEOUT: timeout_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Control and datapath state.
   state_type state_ff, state_in;
   req_type item_ff, item_in;
   rsp_type out_ff, out_in;
   logic out_vld_ff, out_vld_in;
   logic [1:0] axis_ff, axis_in;
   logic step_ff, step_in;       // 0 scale pass, 1 blend pass
   logic go_ff, go_in;           // unit started, wait for busy
   logic signed [RATE_W-1:0] filt_ff [3];
   logic signed [RATE_W-1:0] filt_in [3];
   logic signed [RATE_W-1:0] bias_ff [3];
   logic signed [RATE_W-1:0] bias_in [3];
   logic signed [SUM_WIDTH-1:0] sum_ff [3];
   logic signed [SUM_WIDTH-1:0] sum_in [3];
   logic signed [RATE_W-1:0] x_ff, x_in;
   logic primed_ff, primed_in;
   logic bready_ff, bready_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [23:0] iter_ff, iter_in;
   logic [1:0] phase_ff, phase_in;
   logic neg_ff, neg_in;

   // Shared multiplier.
   logic mul_start, mul_busy;
   logic signed [MA_W-1:0] mul_a;
   logic [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p;

   gfbc_sermul #(.AW(MA_W), .BW(MB_W)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .busy(mul_busy), .prod(mul_p)
   );

   // Shared divider for the bias.
   logic div_start, div_busy;
   logic [SUM_WIDTH-1:0] div_num, div_q;

   gfbc_serdiv #(.NW(SUM_WIDTH), .DW(RUN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(run_ff),
      .busy(div_busy), .quo(div_q)
   );

   req_type req_d;
   assign req_d = req_type'(req.data);
   assign req.ready = (state_ff == ST_IDLE) && !out_vld_ff;
   assign rsp.valid = out_vld_ff;
   assign rsp.data = out_ff;

   logic [2:0] rng;
   logic [8:0] alpha;
   logic signed [RAW_WIDTH-1:0] raw_sel;
   logic [4:0] shamt;
   logic signed [MP_W-1:0] shifted;
   logic signed [RATE_W-1:0] xs;
   logic signed [RATE_W:0] absv [3];
   logic still;
   logic [RUN_W-1:0] need;
   logic [RUN_W-1:0] run_nx;
   logic signed [SUM_WIDTH:0] sum_ext;
   logic signed [SUM_WIDTH:0] qs;
   logic signed [RATE_W:0] diff;

   localparam logic signed [RATE_W-1:0] RMAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0] RMIN = {1'b1, {(RATE_W-1){1'b0}}};
   localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   function automatic logic signed [RATE_W-1:0] sat_p(input logic signed [MP_W-1:0] v);
      if (v > MP_W'(RMAX)) return RMAX;
      if (v < MP_W'(RMIN)) return RMIN;
      return v[RATE_W-1:0];
   endfunction

   always_comb begin
      rng = (range_ff <= 3'd4) ? range_ff : 3'd0;
      alpha = (alpha_ff > 9'd256) ? 9'd256 : alpha_ff;
      unique case (axis_ff)
         2'd0: raw_sel = item_ff.raw_x;
         2'd1: raw_sel = item_ff.raw_y;
         default: raw_sel = item_ff.raw_z;
      endcase
      shamt = 5'(11 + 32'(rng));
      shifted = mul_p >>> shamt;
      xs = sat_p(shifted);
      for (int i = 0; i < 3; i++) begin
         absv[i] = filt_ff[i][RATE_W-1] ? -(RATE_W+1)'(filt_ff[i])
                                        : (RATE_W+1)'(filt_ff[i]);
      end
      still = (absv[0] < (RATE_W+1)'(thresh_ff)) && (absv[1] < (RATE_W+1)'(thresh_ff))
              && (absv[2] < (RATE_W+1)'(thresh_ff));
      need = (count_ff == '0) ? 16'd1 : count_ff;
      run_nx = (run_ff != 16'hFFFF) ? run_ff + 1'b1 : run_ff;
      sum_ext = (SUM_WIDTH+1)'(sum_ff[axis_ff]);
      qs = neg_ff ? -(SUM_WIDTH+1)'(div_q) : (SUM_WIDTH+1)'(div_q);
      diff = (RATE_W+1)'(filt_ff[axis_ff]) - (bready_ff ? (RATE_W+1)'(bias_ff[axis_ff]) : '0);
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff;
      axis_in = axis_ff;
      step_in = step_ff;
      go_in = 1'b0;
      filt_in = filt_ff;
      bias_in = bias_ff;
      sum_in = sum_ff;
      x_in = x_ff;
      primed_in = primed_ff;
      bready_in = bready_ff;
      run_in = run_ff;
      iter_in = iter_ff;
      phase_in = phase_ff;
      neg_in = neg_ff;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_num = '0;
      if (rsp.valid && rsp.ready) begin
         out_vld_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req_d;
               axis_in = 2'd0;
               if (req_d.command) begin
                  phase_in = PHASE_RUN;
                  run_in = '0;
                  iter_in = '0;
                  for (int i = 0; i < 3; i++) sum_in[i] = '0;
                  state_in = ST_OUT;
               end else if (req_d.read_ok) begin
                  step_in = 1'b0;
                  state_in = ST_FILT;
                  go_in = 1'b0;
               end else begin
                  state_in = ST_TEST;
               end
            end
         end
         ST_FILT: begin
            // Start a pass, then collect its product once the unit is done.
            if (!go_ff && !mul_busy) begin
               mul_start = 1'b1;
               go_in = 1'b1;
               if (!step_ff) begin
                  mul_a = MA_W'(raw_sel) <<< RATE_FRAC_BITS;
                  mul_b = MB_W'(125);
               end else begin
                  mul_a = MA_W'(x_ff) - MA_W'(filt_ff[axis_ff]);
                  mul_b = MB_W'(alpha);
               end
            end else if (go_ff) begin
               go_in = 1'b1;
               if (!mul_busy && !mul_start) begin
                  go_in = 1'b0;
               end
               if (!mul_busy) begin
                  go_in = 1'b0;
                  if (!step_ff) begin
                     x_in = xs;
                     if (!primed_ff) begin
                        filt_in[axis_ff] = xs;
                        step_in = 1'b0;
                        if (axis_ff == 2'd2) begin
                           primed_in = 1'b1;
                           state_in = ST_TEST;
                           axis_in = 2'd0;
                        end else begin
                           axis_in = axis_ff + 2'd1;
                        end
                     end else begin
                        step_in = 1'b1;
                     end
                  end else begin
                     // f + alpha*(x-f)/256 equals the weighted sum floor.
                     filt_in[axis_ff] = sat_p((mul_p + (MP_W'(filt_ff[axis_ff]) <<< 8)) >>> 8);
                     step_in = 1'b0;
                     if (axis_ff == 2'd2) begin
                        state_in = ST_TEST;
                        axis_in = 2'd0;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end
               end
            end
         end
         ST_TEST: begin
            axis_in = 2'd0;
            state_in = ST_OUT;
            if (phase_ff == PHASE_RUN) begin
               if (item_ff.read_ok && still) begin
                  run_in = run_nx;
                  for (int i = 0; i < 3; i++) begin
                     sum_in[i] = ((SUM_WIDTH+1)'(sum_ff[i]) + (SUM_WIDTH+1)'(filt_ff[i])
                                  > (SUM_WIDTH+1)'(SMAX)) ? SMAX :
                                 ((SUM_WIDTH+1)'(sum_ff[i]) + (SUM_WIDTH+1)'(filt_ff[i])
                                  < (SUM_WIDTH+1)'(SMIN)) ? SMIN :
                                 sum_ff[i] + SUM_WIDTH'(filt_ff[i]);
                  end
                  if (run_nx >= need) begin
                     phase_in = PHASE_OK;
                     bready_in = 1'b1;
                     state_in = ST_DIV;
                  end
               end else if (item_ff.read_ok) begin
                  run_in = '0;
                  for (int i = 0; i < 3; i++) sum_in[i] = '0;
               end
               if (!(item_ff.read_ok && still && run_nx >= need)) begin
                  if (iter_ff >= timeout_ff) phase_in = PHASE_TIMEOUT;
                  else iter_in = iter_ff + 1'b1;
               end
            end
         end
         ST_DIV: begin
            // Divide |sum| by the run length, one axis at a time.
            if (!go_ff && !div_busy) begin
               div_start = 1'b1;
               go_in = 1'b1;
               neg_in = sum_ext[SUM_WIDTH];
               div_num = sum_ext[SUM_WIDTH] ? SUM_WIDTH'(-sum_ext) : SUM_WIDTH'(sum_ext);
            end else if (go_ff && !div_busy) begin
               bias_in[axis_ff] = (qs > (SUM_WIDTH+1)'(RMAX)) ? RMAX :
                                  (qs < (SUM_WIDTH+1)'(RMIN)) ? RMIN : qs[RATE_W-1:0];
               if (axis_ff == 2'd2) begin
                  axis_in = 2'd0;
                  state_in = ST_OUT;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               go_in = go_ff;
            end
         end
         ST_OUT: begin
            // Build the result beat one axis per cycle.
            if (!out_vld_ff) begin
               if (!item_ff.command && item_ff.read_ok) begin
                  unique case (axis_ff)
                     2'd0: out_in.rate_x = (diff > (RATE_W+1)'(RMAX)) ? RMAX :
                                           (diff < (RATE_W+1)'(RMIN)) ? RMIN : diff[RATE_W-1:0];
                     2'd1: out_in.rate_y = (diff > (RATE_W+1)'(RMAX)) ? RMAX :
                                           (diff < (RATE_W+1)'(RMIN)) ? RMIN : diff[RATE_W-1:0];
                     default: out_in.rate_z = (diff > (RATE_W+1)'(RMAX)) ? RMAX :
                                              (diff < (RATE_W+1)'(RMIN)) ? RMIN :
                                              diff[RATE_W-1:0];
                  endcase
                  out_in.data_valid = 1'b1;
               end else begin
                  out_in.rate_x = '0;
                  out_in.rate_y = '0;
                  out_in.rate_z = '0;
                  out_in.data_valid = 1'b0;
               end
               out_in.bias_valid = bready_ff;
               out_in.cal_status = phase_ff;
               if (axis_ff == 2'd2 || item_ff.command || !item_ff.read_ok) begin
                  out_vld_in = 1'b1;
                  axis_in = 2'd0;
                  state_in = ST_IDLE;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_vld_ff <= 1'b0;
         go_ff <= 1'b0;
         primed_ff <= 1'b0;
         bready_ff <= 1'b0;
         run_ff <= '0;
         iter_ff <= '0;
         phase_ff <= PHASE_IDLE;
         for (int i = 0; i < 3; i++) begin
            filt_ff[i] <= '0;
            bias_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_vld_ff <= out_vld_in;
         go_ff <= go_in;
         primed_ff <= primed_in;
         bready_ff <= bready_in;
         run_ff <= run_in;
         iter_ff <= iter_in;
         phase_ff <= phase_in;
         filt_ff <= filt_in;
         bias_ff <= bias_in;
         sum_ff <= sum_in;
      end
      item_ff <= item_in;
      out_ff <= out_in;
      axis_ff <= axis_in;
      step_ff <= step_in;
      x_ff <= x_in;
      neg_ff <= neg_in;
   end
endmodule

/* src/gfbc_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on gfbc_pkg for nothing beyond house style; standalone.
module gfbc_serdiv
   import gfbc_pkg::*;
#(
   parameter int NW = 40,
   parameter int DW = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic busy,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0] r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] n_ff, n_in;
   logic [DW+1:0] trial;

   // One shift-subtract step per cycle while the counter runs.
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      trial = '0;
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         n_in = CW'(NW);
      end else if (n_ff != '0) begin
         trial = {r_ff, q_ff[NW-1]} - {2'b00, d_ff};
         if (!trial[DW+1]) begin
            r_in = trial[DW:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DW-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = (n_ff != '0);
   assign quo = q_ff;
endmodule

/* src/gfbc_sermul.sv */
// Shift-add multiplier: one multiplier bit per cycle, signed product.
// Standalone; used for scaling and the filter blend.
module gfbc_sermul #(
   parameter int AW = 24,
   parameter int BW = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [AW-1:0] a,
   input  logic [BW-1:0] b,
   output logic busy,
   output logic signed [AW+BW-1:0] prod
);
   localparam int CW = $clog2(BW + 1);
   logic signed [AW+BW-1:0] acc_ff, acc_in;
   logic signed [AW+BW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;
   logic [CW-1:0] n_ff, n_in;

   // Add the shifted multiplicand for each set multiplier bit.
   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      n_in = n_ff;
      if (start) begin
         acc_in = '0;
         a_in = (AW+BW)'(a);
         b_in = b;
         n_in = CW'(BW);
      end else if (n_ff != '0) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = a_ff <<< 1;
         b_in = b_ff >> 1;
         n_in = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign busy = (n_ff != '0);
   assign prod = acc_ff;
endmodule

/* sim/tb_gyro_filter_bias_calibration_top.sv */
// Self-checking testbench for gyro_filter_bias_calibration_top.
// Depends on gfbc_pkg and gfbc_if. A directed table runs first, then random
// sample streams over several register settings, checked by a rate predictor.
module tb_gyro_filter_bias_calibration_top;
   import gfbc_pkg::*;

   typedef struct packed {
      logic command;
      logic read_ok;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } gyro_req_type;

   typedef struct packed {
      logic data_valid;
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
      logic bias_valid;
      logic [1:0] cal_status;
   } gyro_rsp_type;

   typedef struct packed {
      logic typed;
      gyro_req_type beat;
      gyro_rsp_type want;
   } dir_row_type;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START = 1'b1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 172;
   localparam int DIR_ROWS = 14;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   gfbc_if #(.W($bits(gyro_req_type))) req ();
   gfbc_if #(.W($bits(gyro_rsp_type))) rsp ();

   gyro_filter_bias_calibration_top dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor copy of registers and state.
   longint unsigned cfg_range, cfg_alpha, cfg_thresh, cfg_count, cfg_timeout;
   longint filt[3];
   longint bias_val[3];
   longint sums[3];
   bit primed, bias_ok;
   int unsigned still_run, iter_count;
   logic [1:0] phase_now;

   gyro_rsp_type pending_rates[$];
   int mismatches;
   int idle_pct, stall_pct;
   int quiet_cycles;
   dir_row_type directed_rows[DIR_ROWS];

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Advances the predictor by one beat and returns the result it predicts.
   function automatic gyro_rsp_type predict_rates(gyro_req_type b);
      gyro_rsp_type r;
      longint raw[3];
      longint x, alpha, th;
      int unsigned rng, need;
      bit done;
      r = '0;
      raw[0] = b.raw_x;
      raw[1] = b.raw_y;
      raw[2] = b.raw_z;
      done = 1'b0;
      if (b.command == CMD_START) begin
         phase_now = PHASE_RUN;
         still_run = 0;
         iter_count = 0;
         for (int i = 0; i < 3; i++) sums[i] = 0;
      end else begin
         if (b.read_ok) begin
            rng = (cfg_range <= 4) ? int'(cfg_range) : 0;
            alpha = (cfg_alpha > 256) ? 256 : longint'(cfg_alpha);
            for (int i = 0; i < 3; i++) begin
               x = clamp((raw[i] * 125 * 256) >>> (11 + rng), RATE_W);
               if (!primed) filt[i] = x;
               else filt[i] = clamp((alpha * x + (256 - alpha) * filt[i]) >>> 8, RATE_W);
            end
            primed = 1'b1;
            if (phase_now == PHASE_RUN) begin
               th = longint'(cfg_thresh);
               if (magnitude(filt[0]) < th && magnitude(filt[1]) < th &&
                   magnitude(filt[2]) < th) begin
                  need = (cfg_count != 0) ? int'(cfg_count) : 1;
                  if (still_run < 16'hFFFF) still_run++;
                  for (int i = 0; i < 3; i++) sums[i] = clamp(sums[i] + filt[i], 40);
                  if (still_run >= need) begin
                     for (int i = 0; i < 3; i++)
                        bias_val[i] = clamp(sums[i] / longint'(still_run), RATE_W);
                     bias_ok = 1'b1;
                     phase_now = PHASE_OK;
                     done = 1'b1;
                  end
               end else begin
                  still_run = 0;
                  for (int i = 0; i < 3; i++) sums[i] = 0;
               end
            end
         end
         if (phase_now == PHASE_RUN && !done) begin
            if (longint'(iter_count) >= longint'(cfg_timeout)) phase_now = PHASE_TIMEOUT;
            else iter_count++;
         end
         if (b.read_ok) begin
            r.data_valid = 1'b1;
            r.rate_x = RATE_W'(clamp(filt[0] - (bias_ok ? bias_val[0] : 0), RATE_W));
            r.rate_y = RATE_W'(clamp(filt[1] - (bias_ok ? bias_val[1] : 0), RATE_W));
            r.rate_z = RATE_W'(clamp(filt[2] - (bias_ok ? bias_val[2] : 0), RATE_W));
         end
      end
      r.bias_valid = bias_ok;
      r.cal_status = phase_now;
      return r;
   endfunction

   // Writes all five registers, one per clock, and mirrors them in the predictor.
   task automatic write_regs(longint unsigned rng, longint unsigned alpha,
                             longint unsigned th, longint unsigned cnt,
                             longint unsigned tmo);
      logic [CSR_W-1:0] vals[5];
      logic [2:0] idx[5];
      vals[0] = CSR_W'(rng);   idx[0] = REG_RANGE;
      vals[1] = CSR_W'(alpha); idx[1] = REG_ALPHA;
      vals[2] = CSR_W'(th);    idx[2] = REG_THRESH;
      vals[3] = CSR_W'(cnt);   idx[3] = REG_COUNT;
      vals[4] = CSR_W'(tmo);   idx[4] = REG_TIMEOUT;
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_range = rng & 7;
      cfg_alpha = alpha & 'h1FF;
      cfg_thresh = th & 'hFFFFF;
      cfg_count = cnt & 'hFFFF;
      cfg_timeout = tmo & 'hFFFFFF;
   endtask

   // Sends one beat after an optional idle gap and records what it should produce.
   task automatic send_beat(gyro_req_type b, bit typed, gyro_rsp_type want);
      int gap;
      gyro_rsp_type got_pred;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= b;
      do @(posedge clock); while (!req.ready);
      got_pred = predict_rates(b);
      pending_rates.push_back(typed ? want : got_pred);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random beat: mostly still streams that let a calibration finish.
   function automatic gyro_req_type random_beat(int offset);
      gyro_req_type b;
      int pick;
      pick = $urandom_range(99);
      b.command = (pick < 4) ? CMD_START : CMD_SAMPLE;
      b.read_ok = (pick >= 4 && pick < 10) ? 1'b0 : 1'b1;
      if (pick >= 90) begin
         b.raw_x = 16'($urandom);
         b.raw_y = 16'($urandom);
         b.raw_z = 16'($urandom);
      end else begin
         b.raw_x = 16'(offset + $urandom_range(0, 16) - 8);
         b.raw_y = 16'(-offset + $urandom_range(0, 16) - 8);
         b.raw_z = 16'($urandom_range(0, 8) - 4);
      end
      return b;
   endfunction

   // Result checker, ready driver and watchdog.
   always @(posedge clock) begin
      gyro_rsp_type got, want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("gyro_filter_bias_calibration_top verification failed");
            $finish;
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (pending_rates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
               want = pending_rates.pop_front();
               if (got.data_valid !== want.data_valid || got.rate_x !== want.rate_x ||
                   got.rate_y !== want.rate_y || got.rate_z !== want.rate_z ||
                   got.bias_valid !== want.bias_valid ||
                   got.cal_status !== want.cal_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result mismatch: expected dv=%0d x=%0d y=%0d z=%0d ",
                               "bv=%0d st=%0d, got dv=%0d x=%0d y=%0d z=%0d bv=%0d st=%0d"},
                              want.data_valid, want.rate_x, want.rate_y, want.rate_z,
                              want.bias_valid, want.cal_status, got.data_valid, got.rate_x,
                              got.rate_y, got.rate_z, got.bias_valid, got.cal_status);
               end
            end
         end
      end
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Main sequence.
   initial begin
      gyro_req_type b;
      int offset;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      mismatches = 0;
      idle_pct = 0;
      stall_pct = 0;
      cfg_range = 0; cfg_alpha = 77; cfg_thresh = 768; cfg_count = 1500;
      cfg_timeout = 100000;
      for (int i = 0; i < 3; i++) begin
         filt[i] = 0; bias_val[i] = 0; sums[i] = 0;
      end
      primed = 0; bias_ok = 0; still_run = 0; iter_count = 0;
      phase_now = PHASE_IDLE;

      // Directed rows; typed results only where they follow at a glance.
      directed_rows = '{
         '{1'b1, '{CMD_SAMPLE, 1'b1, 16'sd0, 16'sd0, 16'sd0},
           '{1'b1, 21'sd0, 21'sd0, 21'sd0, 1'b0, PHASE_IDLE}},
         '{1'b1, '{CMD_SAMPLE, 1'b0, 16'sh7FFF, -16'sh8000, 16'shFFFF},
           '{1'b0, 21'sd0, 21'sd0, 21'sd0, 1'b0, PHASE_IDLE}},
         '{1'b0, '{CMD_SAMPLE, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b1, -16'sh8000, -16'sh8000, -16'sh8000}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b1, 16'sh7FFF, -16'sh8000, 16'sd0}, '0},
         '{1'b1, '{CMD_START, 1'b0, 16'sd0, 16'sd0, 16'sd0},
           '{1'b0, 21'sd0, 21'sd0, 21'sd0, 1'b0, PHASE_RUN}},
         '{1'b0, '{CMD_SAMPLE, 1'b0, 16'sd0, 16'sd0, 16'sd0}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b1, 16'sd0, 16'sd0, 16'sd0}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b1, 16'sd1, -16'sd1, 16'sd0}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b1, 16'sh5555, -16'sh2AAB, 16'sd3}, '0},
         '{1'b1, '{CMD_START, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
           '{1'b0, 21'sd0, 21'sd0, 21'sd0, 1'b0, PHASE_RUN}},
         '{1'b0, '{CMD_SAMPLE, 1'b1, -16'sd1, -16'sd1, -16'sd1}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b1, 16'sd2, 16'sd0, -16'sd2}, '0},
         '{1'b0, '{CMD_SAMPLE, 1'b0, -16'sh8000, 16'sh7FFF, 16'sh7FFF}, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      drain();

      // Random phases over register settings and idling patterns.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_regs(4, 256, 20000, 1, 0);
            1: write_regs(7, 0, 0, 0, 16'hFFFF);
            2: write_regs(0, 511, 'hFFFFF, 65535, 'hFFFFFF);
            3: write_regs(1, 128, 3000, 8, 300);
            4: write_regs(5, 200, 1500, 20, 60);
            default: write_regs($urandom_range(0, 7), $urandom_range(0, 511),
                                $urandom_range(500, 8000), $urandom_range(1, 30),
                                $urandom_range(5, 200));
         endcase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         offset = $urandom_range(0, 6) - 3;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            b = random_beat(offset);
            send_beat(b, 1'b0, '0);
            // Let the pipeline run dry once mid-phase before carrying on.
            if (p == 3 && n == ITEMS_PER_PHASE / 2) drain();
         end
         drain();
      end

      idle_pct = 0;
      stall_pct = 0;
      req.valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_rates.size() == 0) begin
         $display("gyro_filter_bias_calibration_top verification clean");
      end else begin
         $display("gyro_filter_bias_calibration_top verification failed");
      end
      $finish;
   end
endmodule
